// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/strq_pkg.sv
// Shared widths, codes and defaults for the sorted table range query block.
`default_nettype none

package strq_pkg;

    // Fixed field widths
    localparam int POS_BITS   = 10;
    localparam int ROW_BITS   = 10;
    localparam int SIZE_BITS  = 11;
    localparam int MAXM_BITS  = 7;
    localparam int COUNT_BITS = 11;
    localparam int CFG_IDX_BITS = 1;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BITS_DEF    = 24;
    localparam int MAX_OUT_DEF     = 64;

    // Stand-in key below the table when snapping at position zero
    localparam int FAR_BELOW = -1000000;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_MATCHES = 1'b1;

    // Status codes
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_TABLE = 1'b1;

endpackage

`default_nettype wire

// File: rtl/sorted_table_range_query.sv
// Sorted table range query: table memory, binary search sequencer and row emitter.
//
//   channel  | signals                      | payload
//   ---------+------------------------------+-------------------------------------------
//   in       | in_valid / in_ready          | cmd, position, entry_key, entry_row,
//            |                              | range_low, range_high, use_neighbours,
//            |                              | count_only
//   out      | out_valid / out_ready        | match_row, row_valid, last, match_count,
//            |                              | insert_position, status
//   cfg      | cfg_wr_en, cfg_index         | cfg_wdata
//
// A load is written to the table as it is accepted and leaves the sequencer idle. The
// binary search, the neighbour snap and walk-back, and the emit loop all share the
// single read port of the key memory.
// in_ready is high only while the sequencer is idle; a result stalled at the output
// register holds the emit loop. Reset clears control state only; the table is undefined
// until loaded.
`default_nettype none

module sorted_table_range_query #(
    parameter int TABLE_DEPTH = strq_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = strq_pkg::KEY_BITS_DEF,
    parameter int MAX_OUT     = strq_pkg::MAX_OUT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 cfg_wr_en,
    input  wire logic [strq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [strq_pkg::SIZE_BITS-1:0]       cfg_wdata,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 cmd,
    input  wire logic [strq_pkg::POS_BITS-1:0]        position,
    input  wire logic [KEY_BITS-1:0]                  entry_key,
    input  wire logic [strq_pkg::ROW_BITS-1:0]        entry_row,
    input  wire logic [KEY_BITS-1:0]                  range_low,
    input  wire logic [KEY_BITS-1:0]                  range_high,
    input  wire logic                                 use_neighbours,
    input  wire logic                                 count_only,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [strq_pkg::ROW_BITS-1:0]             match_row,
    output logic                                      row_valid,
    output logic                                      last,
    output logic [strq_pkg::COUNT_BITS-1:0]           match_count,
    output logic [strq_pkg::COUNT_BITS-1:0]           insert_position,
    output logic                                      status
);

    localparam int RB = strq_pkg::ROW_BITS;
    localparam int CB = strq_pkg::COUNT_BITS;
    localparam int SB = strq_pkg::SIZE_BITS;
    localparam int MB = strq_pkg::MAXM_BITS;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (PW > MB) ? PW : MB;
    localparam int SW = ((KEY_BITS > 21) ? KEY_BITS : 21) + 3;
    localparam logic signed [SW-1:0] FAR_KEY = SW'(strq_pkg::FAR_BELOW);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FIRST   = 4'd1;
    localparam logic [3:0] S_LAST    = 4'd2;
    localparam logic [3:0] S_SRCH    = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_POS     = 4'd5;
    localparam logic [3:0] S_BEFORE  = 4'd6;
    localparam logic [3:0] S_WALK    = 4'd7;
    localparam logic [3:0] S_WALKCMP = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;
    localparam logic [3:0] S_STEP    = 4'd10;
    localparam logic [3:0] S_FINAL   = 4'd11;

    function automatic logic signed [SW-1:0] sx(input logic [KEY_BITS-1:0] k);
        sx = $signed(SW'(k));
    endfunction

    // config registers
    logic [SB-1:0] table_size_reg;
    logic [MB-1:0] max_matches_reg;

    // table memory
    logic [KEY_BITS-1:0] sorted_keys [TABLE_DEPTH];
    logic [RB-1:0]       row_numbers [TABLE_DEPTH];
    logic [KEY_BITS-1:0] key_q;
    logic [RB-1:0]       row_q;
    logic                key_rd_en;
    logic [AW-1:0]       key_rd_addr;
    logic                row_rd_en;
    logic [AW-1:0]       row_rd_addr;
    logic                load_we;

    // sequencer
    logic [3:0]            state_reg, state_next;
    logic signed [SW-1:0]  lo_reg, lo_next;
    logic signed [SW-1:0]  hi_reg, hi_next;
    logic                  neigh_reg, neigh_next;
    logic                  conly_reg, conly_next;
    logic [KEY_BITS-1:0]   first_reg, first_next;
    logic [KEY_BITS-1:0]   kp_reg, kp_next;
    logic [PW-1:0]         a_reg, a_next;
    logic [PW-1:0]         b_reg, b_next;
    logic [PW-1:0]         m_reg, m_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [PW-1:0]         num_reg, num_next;
    logic [CB-1:0]         fin_count_reg, fin_count_next;
    logic [CB-1:0]         fin_ins_reg, fin_ins_next;
    logic                  fin_status_reg, fin_status_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [RB-1:0] out_row_reg, out_row_next;
    logic          out_rv_reg, out_rv_next;
    logic          out_last_reg, out_last_next;
    logic [CB-1:0] out_count_reg, out_count_next;
    logic [CB-1:0] out_ins_reg, out_ins_next;
    logic          out_status_reg, out_status_next;

    // datapath helpers
    logic [PW-1:0]        n_eff;
    logic [MB-1:0]        limit;
    logic [PW:0]          mid_sum;
    logic [PW-1:0]        mid;
    logic [PW-1:0]        pos_dec;
    logic [PW-1:0]        pos_inc;
    logic [PW-1:0]        num_inc;
    logic signed [SW-1:0] key_s;
    logic signed [SW-1:0] kp_s;
    logic signed [SW-1:0] first_s;
    logic signed [SW-1:0] lo1, hi1, lo2, hi2, before_s;
    logic                 hi_above, lo_above, out_free, more, cont, accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign load_we  = accept && (cmd == strq_pkg::CMD_LOAD) && (32'(position) < TABLE_DEPTH);

    assign n_eff = (32'(table_size_reg) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(table_size_reg);
    assign limit = (max_matches_reg > MB'(MAX_OUT)) ? MB'(MAX_OUT) : max_matches_reg;

    assign mid_sum = {1'b0, a_reg} + {1'b0, b_reg};
    assign mid     = mid_sum[PW:1];
    assign pos_dec = pos_reg - 1'b1;
    assign pos_inc = pos_reg + 1'b1;
    assign num_inc = num_reg + 1'b1;
    assign key_s   = sx(key_q);
    assign kp_s    = sx(kp_reg);
    assign first_s = sx(first_reg);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= '0;
            max_matches_reg <= MB'(64);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                strq_pkg::REG_TABLE_SIZE:  table_size_reg  <= cfg_wdata;
                strq_pkg::REG_MAX_MATCHES: max_matches_reg <= cfg_wdata[MB-1:0];
                default: ;
            endcase
        end
    end

    // table memory: one write port, one registered read port per array
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            sorted_keys[AW'(position)] <= entry_key;
            row_numbers[AW'(position)] <= entry_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_rd_en)
        begin
            key_q <= sorted_keys[key_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_rd_en)
        begin
            row_q <= row_numbers[row_rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        neigh_next      = neigh_reg;
        conly_next      = conly_reg;
        first_next      = first_reg;
        kp_next         = kp_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        m_next          = m_reg;
        pos_next        = pos_reg;
        num_next        = num_reg;
        fin_count_next  = fin_count_reg;
        fin_ins_next    = fin_ins_reg;
        fin_status_next = fin_status_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_row_next    = out_row_reg;
        out_rv_next     = out_rv_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_ins_next    = out_ins_reg;
        out_status_next = out_status_reg;

        key_rd_en   = 1'b0;
        key_rd_addr = '0;
        row_rd_en   = 1'b0;
        row_rd_addr = '0;

        hi_above = hi_reg > key_s;
        lo_above = lo_reg > key_s;
        hi1      = hi_above ? key_s : hi_reg;
        lo1      = (hi_above && lo_above) ? hi1 : lo_reg;
        lo2      = (lo1 < first_s) ? first_s : lo1;
        hi2      = hi1;
        before_s = (pos_reg == '0) ? FAR_KEY : key_s;
        more     = (pos_inc < n_eff) && (key_s <= hi_reg);
        cont     = more && (conly_reg || (LW'(num_inc) < LW'(limit)));

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == strq_pkg::CMD_QUERY))
                begin
                    lo_next    = sx(range_low);
                    hi_next    = sx(range_high);
                    neigh_next = use_neighbours;
                    conly_next = count_only;
                    if (n_eff == '0)
                    begin
                        fin_count_next  = '0;
                        fin_ins_next    = '0;
                        fin_status_next = strq_pkg::STATUS_NO_TABLE;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        key_rd_en  = 1'b1;
                        state_next = S_FIRST;
                    end
                end
            end

            S_FIRST:
            begin
                first_next  = key_q;
                key_rd_en   = 1'b1;
                key_rd_addr = AW'(n_eff - 1'b1);
                state_next  = S_LAST;
            end

            // clip both bounds to the key span, or finish early when the range misses it without neighbours
            S_LAST:
            begin
                fin_status_next = strq_pkg::STATUS_DONE;
                fin_count_next  = '0;
                num_next        = '0;
                if (hi_above && lo_above && !neigh_reg)
                begin
                    fin_ins_next = CB'(n_eff);
                    state_next   = S_FINAL;
                end
                else if ((lo1 < first_s) && (hi1 < first_s) && !neigh_reg)
                begin
                    fin_ins_next = '0;
                    state_next   = S_FINAL;
                end
                else
                begin
                    if ((lo1 < first_s) && (hi1 < first_s))
                    begin
                        hi2 = lo2;
                    end
                    lo_next    = lo2;
                    hi_next    = hi2;
                    a_next     = '0;
                    b_next     = n_eff;
                    state_next = S_SRCH;
                end
            end

            S_SRCH:
            begin
                if (a_reg < b_reg)
                begin
                    m_next      = mid;
                    key_rd_en   = 1'b1;
                    key_rd_addr = mid[AW-1:0];
                    state_next  = S_CMP;
                end
                else
                begin
                    pos_next = a_reg;
                    if (a_reg >= n_eff)
                    begin
                        fin_ins_next = CB'(n_eff);
                        state_next   = S_FINAL;
                    end
                    else
                    begin
                        key_rd_en   = 1'b1;
                        key_rd_addr = a_reg[AW-1:0];
                        state_next  = S_POS;
                    end
                end
            end

            S_CMP:
            begin
                if (key_s < lo_reg)
                begin
                    a_next = m_reg + 1'b1;
                end
                else
                begin
                    b_next = m_reg;
                end
                state_next = S_SRCH;
            end

            S_POS:
            begin
                kp_next = key_q;
                if (neigh_reg && (key_s != lo_reg))
                begin
                    if (pos_reg != '0)
                    begin
                        key_rd_en   = 1'b1;
                        key_rd_addr = pos_dec[AW-1:0];
                    end
                    state_next = S_BEFORE;
                end
                else if ((key_s == lo_reg) || ((key_s > lo_reg) && (key_s <= hi_reg)))
                begin
                    lo_next    = key_s;
                    state_next = S_EMIT;
                end
                else
                begin
                    fin_ins_next = CB'(pos_reg);
                    state_next   = S_FINAL;
                end
            end

            // snap to the nearer neighbour, upper one on a tie
            S_BEFORE:
            begin
                if ((kp_s - lo_reg) <= (lo_reg - before_s))
                begin
                    lo_next    = kp_s;
                    state_next = S_EMIT;
                end
                else
                begin
                    lo_next = before_s;
                    if (pos_reg != '0)
                    begin
                        pos_next   = pos_dec;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        fin_ins_next = '0;
                        state_next   = S_FINAL;
                    end
                end
            end

            // walk back to the first of a run of equal keys
            S_WALK:
            begin
                if (pos_reg != '0)
                begin
                    key_rd_en   = 1'b1;
                    key_rd_addr = pos_dec[AW-1:0];
                    state_next  = S_WALKCMP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_WALKCMP:
            begin
                if (key_s == lo_reg)
                begin
                    pos_next   = pos_dec;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!conly_reg && (LW'(num_reg) >= LW'(limit)))
                begin
                    fin_count_next = CB'(num_reg);
                    fin_ins_next   = CB'(pos_reg);
                    state_next     = S_FINAL;
                end
                else
                begin
                    row_rd_en   = 1'b1;
                    row_rd_addr = pos_reg[AW-1:0];
                    key_rd_en   = 1'b1;
                    key_rd_addr = pos_inc[AW-1:0];
                    state_next  = S_STEP;
                end
            end

            // key_q holds the next key, row_q the row to emit
            S_STEP:
            begin
                if (conly_reg)
                begin
                    num_next = num_inc;
                    pos_next = pos_inc;
                    if (more)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        fin_count_next = CB'(num_inc);
                        fin_ins_next   = CB'(pos_inc);
                        state_next     = S_FINAL;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = row_q;
                    out_rv_next     = 1'b1;
                    out_last_next   = !cont;
                    out_count_next  = cont ? '0 : CB'(num_inc);
                    out_ins_next    = cont ? '0 : CB'(pos_inc);
                    out_status_next = strq_pkg::STATUS_DONE;
                    num_next        = num_inc;
                    pos_next        = pos_inc;
                    state_next      = cont ? S_EMIT : S_IDLE;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = '0;
                    out_rv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    out_count_next  = fin_count_reg;
                    out_ins_next    = fin_ins_reg;
                    out_status_next = fin_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        neigh_reg       <= neigh_next;
        conly_reg       <= conly_next;
        first_reg       <= first_next;
        kp_reg          <= kp_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        m_reg           <= m_next;
        pos_reg         <= pos_next;
        num_reg         <= num_next;
        fin_count_reg   <= fin_count_next;
        fin_ins_reg     <= fin_ins_next;
        fin_status_reg  <= fin_status_next;
        out_row_reg     <= out_row_next;
        out_rv_reg      <= out_rv_next;
        out_last_reg    <= out_last_next;
        out_count_reg   <= out_count_next;
        out_ins_reg     <= out_ins_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign match_row       = out_row_reg;
    assign row_valid       = out_rv_reg;
    assign last            = out_last_reg;
    assign match_count     = out_count_reg;
    assign insert_position = out_ins_reg;
    assign status          = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/strq_chk.sv
// Port-level checker for the sorted table range query block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module strq_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [strq_pkg::ROW_BITS-1:0]    match_row,
    input wire logic                             row_valid,
    input wire logic                             last,
    input wire logic [strq_pkg::COUNT_BITS-1:0]  match_count,
    input wire logic [strq_pkg::COUNT_BITS-1:0]  insert_position,
    input wire logic                             status
);

    // a stalled beat holds
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(match_row) && $stable(last) && $stable(row_valid), "output beat changed while stalled")

    // a beat without a row always closes the query
    `ASSERT_CLK(a_norow_last, out_valid && !row_valid |-> last, "row-less beat not marked last")

    // no-table result carries nothing else
    `ASSERT_CLK(a_notable, out_valid && (status == strq_pkg::STATUS_NO_TABLE) |-> !row_valid && (match_count == '0) && (insert_position == '0), "no-table beat carries data")

    // no new item while a query is still emitting rows
    `ASSERT_CLK(a_busy, out_valid && !last |-> !in_ready, "input taken mid-query")

    `ASSERT_CLK_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind sorted_table_range_query strq_chk u_strq_chk (.*);

`default_nettype wire
